// File: design/backtracker_maze_carver_defines.svh
// Assertion macros shared by the maze carver RTL.
`ifndef BACKTRACKER_MAZE_CARVER_DEFINES_SVH
`define BACKTRACKER_MAZE_CARVER_DEFINES_SVH

// Same-cycle implication, checked on every aclk edge outside reset.
`define BMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every aclk edge outside reset.
`define BMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bmc_pkg.sv
// Types, codes and helpers for the maze carver.
`default_nettype none

package bmc_pkg;

    localparam int RND_W  = 15;  // random word width
    localparam int CFG_W  = 7;   // dimension register width
    localparam int OUT_CW = 6;   // reported coordinate width
    localparam int SIDES  = 4;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd16;

    // configuration register indexes
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // wall sides
    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_EAST  = 2'd1;
    localparam logic [1:0] SIDE_SOUTH = 2'd2;
    localparam logic [1:0] SIDE_WEST  = 2'd3;

    typedef enum logic [2:0] {
        EV_CARVE     = 3'd0,
        EV_BACKTRACK = 3'd1,
        EV_ENTRANCE  = 3'd2,
        EV_EXIT      = 3'd3,
        EV_IGNORED   = 3'd4
    } event_kind_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TOP   = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_MOD   = 7'b0001000,
        ST_CLEAR = 7'b0010000,
        ST_SEED  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    // x mod 3: base-4 digits sum to the same residue, folded twice
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] x);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6])
          + 5'(x[9:8]) + 5'(x[11:10]) + 5'(x[13:12]) + 5'(x[14]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/backtracker_maze_carver.sv
// Top level of the depth-first (recursive backtracker) maze carver.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------------
//  s_      | in        | s_valid / s_ready | s_req_type, s_random_value
//  m_      | out       | m_valid / m_ready | m_event_kind, m_cell_col, m_cell_row,
//          |           |                   | m_wall_side, m_finished
//  cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
//  One beat at a time. A carve or backtrack raises m_valid after the stack read, the neighbor
//  scan and the result load; the next beat is taken once the block is back in idle. An exit
//  adds the bit-serial remainder, an ignored step goes straight to the result load, and a
//  start runs the remainder, the visited RAM clearing sweep and the entrance seed.
//  aresetn is synchronous; it clears control state only, RAM contents are not reset.
//  A stalled result holds the output register; the next result then waits with s_ready low.
`default_nettype none
`include "backtracker_maze_carver_defines.svh"

module backtracker_maze_carver
    import bmc_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    // requests
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_req_type,
    input  wire logic [RND_W-1:0]    s_random_value,
    // results
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_event_kind,
    output logic [OUT_CW-1:0]        m_cell_col,
    output logic [OUT_CW-1:0]        m_cell_row,
    output logic [1:0]               m_wall_side,
    output logic                     m_finished
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW   = $clog2(CELL_COUNT);      // RAM address
    localparam int DW   = $clog2(CELL_COUNT + 1);  // stack depth counter
    localparam int CW   = $clog2(MAX_COLS);        // column coordinate
    localparam int RW   = $clog2(MAX_ROWS);        // row coordinate
    localparam int CW1  = $clog2(MAX_COLS + 1);    // effective column count
    localparam int RW1  = $clog2(MAX_ROWS + 1);    // effective row count
    localparam int CXW  = CW + 1;                  // neighbor column with carry
    localparam int RXW  = RW + 1;                  // neighbor row with borrow
    localparam int CNTW = $clog2(RND_W);
    localparam logic [2:0] SCAN_LAST = 3'(SIDES);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t            state_reg,   state_next;
    logic              running_reg, running_next;
    logic [DW-1:0]     depth_reg,   depth_next;
    logic [CFG_W-1:0]  cols_cfg_reg, cols_cfg_next;
    logic [CFG_W-1:0]  rows_cfg_reg, rows_cfg_next;
    logic              m_valid_reg, m_valid_next;

    logic              req_reg,     req_next;
    logic [RND_W-1:0]  rnd_reg,     rnd_next;
    logic [CW-1:0]     top_col_reg, top_col_next;
    logic [RW-1:0]     top_row_reg, top_row_next;
    logic [2:0]        scan_reg,    scan_next;
    logic              inb_reg,     inb_next;
    logic [SIDES-2:0]  mask_reg,    mask_next;
    logic [RW1-1:0]    rem_reg,     rem_next;
    logic [RND_W-1:0]  dsh_reg,     dsh_next;
    logic [CNTW-1:0]   dcnt_reg,    dcnt_next;
    logic [AW-1:0]     clr_reg,     clr_next;

    event_kind_t       res_kind_reg, res_kind_next;
    logic [OUT_CW-1:0] res_col_reg,  res_col_next;
    logic [OUT_CW-1:0] res_row_reg,  res_row_next;
    logic [1:0]        res_side_reg, res_side_next;
    logic              res_fin_reg,  res_fin_next;

    logic [2:0]        m_kind_reg,   m_kind_next;
    logic [OUT_CW-1:0] m_col_reg,    m_col_next;
    logic [OUT_CW-1:0] m_row_reg,    m_row_next;
    logic [1:0]        m_side_reg,   m_side_next;
    logic              m_fin_reg,    m_fin_next;

    // ------------------------------------------------------------------
    // Memories: visited map (1 bit per cell) and path stack ({col,row})
    // ------------------------------------------------------------------
    logic              vis_we;
    logic [AW-1:0]     vis_waddr, vis_raddr;
    logic              vis_wdata, vis_rdata;

    logic              stk_we;
    logic [AW-1:0]     stk_waddr, stk_raddr;
    logic [CW+RW-1:0]  stk_wdata, stk_rdata;

    bmc_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_visited (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    bmc_ram #(.WIDTH(CW + RW), .DEPTH(CELL_COUNT)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------------
    // Effective grid size: 0 acts as 1, large values saturate
    // ------------------------------------------------------------------
    logic [CW1-1:0] cols_eff;
    logic [RW1-1:0] rows_eff;

    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_eff = CW1'(1);
        end else if (int'(cols_cfg_reg) > MAX_COLS) begin
            cols_eff = CW1'(MAX_COLS);
        end else begin
            cols_eff = CW1'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_eff = RW1'(1);
        end else if (int'(rows_cfg_reg) > MAX_ROWS) begin
            rows_eff = RW1'(MAX_ROWS);
        end else begin
            rows_eff = RW1'(rows_cfg_reg);
        end
    end

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                input logic [RW-1:0] r);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // ------------------------------------------------------------------
    // Neighbors of the top cell, in scan order N, E, S, W
    // ------------------------------------------------------------------
    logic [CW-1:0] nb_col  [SIDES];
    logic [RW-1:0] nb_row  [SIDES];
    logic          nb_in   [SIDES];
    logic [AW-1:0] nb_addr [SIDES];

    logic [CXW-1:0] colx, colsx, col_inc, col_dec;
    logic [RXW-1:0] rowx, rowsx, row_inc, row_dec;

    always_comb begin
        colx    = CXW'(top_col_reg);
        rowx    = RXW'(top_row_reg);
        colsx   = CXW'(cols_eff);
        rowsx   = RXW'(rows_eff);
        col_inc = colx + CXW'(1);
        col_dec = colx - CXW'(1);
        row_inc = rowx + RXW'(1);
        row_dec = rowx - RXW'(1);

        nb_col[SIDE_NORTH] = top_col_reg;
        nb_row[SIDE_NORTH] = row_dec[RW-1:0];
        nb_in[SIDE_NORTH]  = (top_row_reg != '0) && (colx < colsx) && (row_dec < rowsx);

        nb_col[SIDE_EAST]  = col_inc[CW-1:0];
        nb_row[SIDE_EAST]  = top_row_reg;
        nb_in[SIDE_EAST]   = (col_inc < colsx) && (rowx < rowsx);

        nb_col[SIDE_SOUTH] = top_col_reg;
        nb_row[SIDE_SOUTH] = row_inc[RW-1:0];
        nb_in[SIDE_SOUTH]  = (colx < colsx) && (row_inc < rowsx);

        nb_col[SIDE_WEST]  = col_dec[CW-1:0];
        nb_row[SIDE_WEST]  = top_row_reg;
        nb_in[SIDE_WEST]   = (top_col_reg != '0) && (col_dec < colsx) && (rowx < rowsx);

        for (int s = 0; s < SIDES; s++) begin
            nb_addr[s] = cell_addr(nb_col[s], nb_row[s]);
        end
    end

    // ------------------------------------------------------------------
    // Candidate choice at the end of the scan
    // ------------------------------------------------------------------
    logic [SIDES-1:0] cand_mask;
    logic [2:0]       cand_cnt;
    logic [1:0]       pick;
    logic [1:0]       pick_side;
    logic [2:0]       seen;

    always_comb begin
        // last side's visited bit arrives in the final scan cycle
        cand_mask = {inb_reg & ~vis_rdata, mask_reg};
        cand_cnt  = 3'(cand_mask[0]) + 3'(cand_mask[1]) + 3'(cand_mask[2])
                  + 3'(cand_mask[3]);
        case (cand_cnt)
            3'd2:    pick = {1'b0, rnd_reg[0]};
            3'd3:    pick = mod3(rnd_reg);
            3'd4:    pick = rnd_reg[1:0];
            default: pick = 2'd0;
        endcase
        pick_side = SIDE_NORTH;
        seen      = 3'd0;
        for (int s = 0; s < SIDES; s++) begin
            if (cand_mask[s]) begin
                if (seen == {1'b0, pick}) begin
                    pick_side = 2'(s);
                end
                seen = seen + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bit-serial remainder: random_value mod rows, one bit per cycle
    // ------------------------------------------------------------------
    logic [RW1:0]   rem_trial;
    logic [RW1-1:0] rem_step;
    logic           dcnt_last;

    always_comb begin
        rem_trial = {rem_reg, dsh_reg[RND_W-1]};
        if (rem_trial >= (RW1 + 1)'(rows_eff)) begin
            rem_step = RW1'(rem_trial - (RW1 + 1)'(rows_eff));
        end else begin
            rem_step = RW1'(rem_trial);
        end
        dcnt_last = (dcnt_reg == CNTW'(RND_W - 1));
    end

    // ------------------------------------------------------------------
    // Stack pointer views
    // ------------------------------------------------------------------
    logic [DW-1:0] depth_m1;
    assign depth_m1  = depth_reg - DW'(1);
    // top of stack is always being read; valid in the cycle after accept
    assign stk_raddr = depth_m1[AW-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        running_next  = running_reg;
        depth_next    = depth_reg;
        cols_cfg_next = cols_cfg_reg;
        rows_cfg_next = rows_cfg_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        req_next      = req_reg;
        rnd_next      = rnd_reg;
        top_col_next  = top_col_reg;
        top_row_next  = top_row_reg;
        scan_next     = scan_reg;
        inb_next      = inb_reg;
        mask_next     = mask_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        dcnt_next     = dcnt_reg;
        clr_next      = clr_reg;

        res_kind_next = res_kind_reg;
        res_col_next  = res_col_reg;
        res_row_next  = res_row_reg;
        res_side_next = res_side_reg;
        res_fin_next  = res_fin_reg;

        m_kind_next   = m_kind_reg;
        m_col_next    = m_col_reg;
        m_row_next    = m_row_reg;
        m_side_next   = m_side_reg;
        m_fin_next    = m_fin_reg;

        vis_we    = 1'b0;
        vis_waddr = clr_reg;
        vis_wdata = 1'b0;
        vis_raddr = nb_addr[scan_reg[1:0]];
        stk_we    = 1'b0;
        stk_waddr = depth_reg[AW-1:0];
        stk_wdata = {nb_col[pick_side], nb_row[pick_side]};

        s_ready = (state_reg == ST_IDLE);

        // writes are taken as they come; the user is to issue them only while idle, the block does not enforce it
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_COLUMNS: cols_cfg_next = cfg_wdata;
                REG_GRID_ROWS:    rows_cfg_next = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_req_type;
                    rnd_next = s_random_value;
                    if (s_req_type == REQ_START) begin
                        rem_next   = '0;
                        dsh_next   = s_random_value;
                        dcnt_next  = '0;
                        state_next = ST_MOD;
                    end else if (!running_reg || depth_reg == '0) begin
                        running_next  = 1'b0;
                        res_kind_next = EV_IGNORED;
                        res_col_next  = '0;
                        res_row_next  = '0;
                        res_side_next = SIDE_NORTH;
                        res_fin_next  = 1'b0;
                        state_next    = ST_EMIT;
                    end else begin
                        state_next = ST_TOP;
                    end
                end
            end

            ST_TOP: begin
                top_col_next = stk_rdata[CW+RW-1:RW];
                top_row_next = stk_rdata[RW-1:0];
                scan_next    = '0;
                mask_next    = '0;
                state_next   = ST_SCAN;
            end

            ST_SCAN: begin
                // issue side k, collect side k-1 from the previous read
                inb_next  = nb_in[scan_reg[1:0]];
                scan_next = scan_reg + 3'd1;
                case (scan_reg)
                    3'd1:    mask_next[0] = inb_reg & ~vis_rdata;
                    3'd2:    mask_next[1] = inb_reg & ~vis_rdata;
                    3'd3:    mask_next[2] = inb_reg & ~vis_rdata;
                    default: mask_next    = mask_reg;
                endcase
                if (scan_reg == SCAN_LAST) begin
                    res_col_next = OUT_CW'(top_col_reg);
                    res_row_next = OUT_CW'(top_row_reg);
                    res_fin_next = 1'b0;
                    if (cand_cnt != '0) begin
                        // carve toward the chosen neighbor and push it
                        res_kind_next = EV_CARVE;
                        res_side_next = pick_side;
                        vis_we        = 1'b1;
                        vis_waddr     = nb_addr[pick_side];
                        vis_wdata     = 1'b1;
                        if (depth_reg < DW'(CELL_COUNT)) begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                        state_next = ST_EMIT;
                    end else if (depth_reg > DW'(1)) begin
                        res_kind_next = EV_BACKTRACK;
                        res_side_next = SIDE_NORTH;
                        depth_next    = depth_m1;
                        state_next    = ST_EMIT;
                    end else begin
                        // bottom cell exhausted: exit row needs the remainder
                        rem_next   = '0;
                        dsh_next   = rnd_reg;
                        dcnt_next  = '0;
                        state_next = ST_MOD;
                    end
                end
            end

            ST_MOD: begin
                rem_next  = rem_step;
                dsh_next  = {dsh_reg[RND_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + CNTW'(1);
                if (dcnt_last) begin
                    if (req_reg == REQ_START) begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        running_next  = 1'b0;
                        depth_next    = '0;
                        res_kind_next = EV_EXIT;
                        res_col_next  = OUT_CW'(cols_eff - CW1'(1));
                        res_row_next  = OUT_CW'(rem_step);
                        res_side_next = SIDE_EAST;
                        res_fin_next  = 1'b1;
                        state_next    = ST_EMIT;
                    end
                end
            end

            ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = 1'b0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(CELL_COUNT - 1)) begin
                    state_next = ST_SEED;
                end
            end

            ST_SEED: begin
                // entrance cell (0, row): mark, push as the only stack entry
                vis_we        = 1'b1;
                vis_waddr     = cell_addr('0, RW'(rem_reg));
                vis_wdata     = 1'b1;
                stk_we        = 1'b1;
                stk_waddr     = '0;
                stk_wdata     = {CW'(0), RW'(rem_reg)};
                depth_next    = DW'(1);
                running_next  = 1'b1;
                res_kind_next = EV_ENTRANCE;
                res_col_next  = '0;
                res_row_next  = OUT_CW'(rem_reg);
                res_side_next = SIDE_WEST;
                res_fin_next  = 1'b0;
                state_next    = ST_EMIT;
            end

            ST_EMIT: begin
                // output register frees when empty or drained this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_col_next   = res_col_reg;
                    m_row_next   = res_row_reg;
                    m_side_next  = res_side_reg;
                    m_fin_next   = res_fin_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            running_reg  <= 1'b0;
            depth_reg    <= '0;
            cols_cfg_reg <= CFG_DIM_RESET;
            rows_cfg_reg <= CFG_DIM_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            depth_reg    <= depth_next;
            cols_cfg_reg <= cols_cfg_next;
            rows_cfg_reg <= rows_cfg_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        rnd_reg      <= rnd_next;
        top_col_reg  <= top_col_next;
        top_row_reg  <= top_row_next;
        scan_reg     <= scan_next;
        inb_reg      <= inb_next;
        mask_reg     <= mask_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        dcnt_reg     <= dcnt_next;
        clr_reg      <= clr_next;
        res_kind_reg <= res_kind_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_side_reg <= res_side_next;
        res_fin_reg  <= res_fin_next;
        m_kind_reg   <= m_kind_next;
        m_col_reg    <= m_col_next;
        m_row_reg    <= m_row_next;
        m_side_reg   <= m_side_next;
        m_fin_reg    <= m_fin_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_cell_col   = m_col_reg;
    assign m_cell_row   = m_row_reg;
    assign m_wall_side  = m_side_reg;
    assign m_finished   = m_fin_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BMC_ASSERT_NOW(a_depth_bound, 1'b1, depth_reg <= DW'(CELL_COUNT),
                    "stack depth beyond grid size")
    `BMC_ASSERT_NOW(a_running_has_cell, (state_reg == ST_IDLE) && running_reg,
                    depth_reg != '0, "running with empty stack")
    `BMC_ASSERT_NEXT(a_exit_stops, (state_reg == ST_MOD) && dcnt_last && (req_reg == REQ_STEP),
                     !running_reg && (depth_reg == '0) && (res_kind_reg == EV_EXIT),
                     "exit did not stop the carver")

endmodule

`default_nettype wire

// File: design/bmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the depth-first maze carver.
module testbench;
    import bmc_pkg::*;

    // Grid bounds passed to the block; the predictor uses the same ones.
    localparam int GRID_MAX     = 64;
    localparam int GRID_CELLS   = GRID_MAX * GRID_MAX;
    localparam int RANDOM_ITEMS = 1100;
    // A start sweeps the whole visited RAM clear, so the watchdog has to
    // allow several times that sweep with no beat moving.
    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        event_kind_t       kind;
        logic [OUT_CW-1:0] col;
        logic [OUT_CW-1:0] row;
        logic [1:0]        side;
        logic              fin;
    } maze_event_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_LONG_STALLS,
        RDY_TOGGLE
    } ready_mode_t;

    logic             aclk           = 1'b0;
    logic             aresetn        = 1'b0;
    logic             cfg_wr_en      = 1'b0;
    logic             cfg_index      = REG_GRID_COLUMNS;
    logic [CFG_W-1:0] cfg_wdata      = '0;
    logic             s_valid        = 1'b0;
    logic             s_ready;
    logic             s_req_type     = REQ_STEP;
    logic [RND_W-1:0] s_random_value = '0;
    logic             m_valid;
    logic             m_ready        = 1'b0;
    logic [2:0]        m_event_kind;
    logic [OUT_CW-1:0] m_cell_col;
    logic [OUT_CW-1:0] m_cell_row;
    logic [1:0]        m_wall_side;
    logic              m_finished;

    backtracker_maze_carver #(
        .MAX_COLS(GRID_MAX),
        .MAX_ROWS(GRID_MAX)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_random_value(s_random_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_cell_col    (m_cell_col),
        .m_cell_row    (m_cell_row),
        .m_wall_side   (m_wall_side),
        .m_finished    (m_finished)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Maze predictor: its own copy of the dimension registers, visited
    // map, path stack and run flag. Updated once per accepted request.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  grid_cols_raw = CFG_DIM_RESET;
    logic [CFG_W-1:0]  grid_rows_raw = CFG_DIM_RESET;
    bit [GRID_CELLS-1:0] visited_cells;
    logic [OUT_CW-1:0] trail_col [GRID_CELLS];
    logic [OUT_CW-1:0] trail_row [GRID_CELLS];
    int                trail_depth = 0;
    bit                carving     = 1'b0;

    maze_event_t pending_events[$];   // predicted result beats, oldest first
    int          mismatches = 0;
    int          work_items = 0;      // accepted requests that did something

    // Zero acts as one, anything past the grid bound saturates.
    function automatic int effective_dim(logic [CFG_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > GRID_MAX) begin
            return GRID_MAX;
        end
        return int'(raw);
    endfunction

    function automatic void mark_and_push(int col, int row);
        visited_cells[row * GRID_MAX + col] = 1'b1;
        // a full stack cannot happen since every push marks a fresh cell
        if (trail_depth < GRID_CELLS) begin
            trail_col[trail_depth] = OUT_CW'(col);
            trail_row[trail_depth] = OUT_CW'(row);
            trail_depth++;
        end
    endfunction

    function automatic maze_event_t predict_carve(logic req, logic [RND_W-1:0] rnd);
        maze_event_t ev;
        int          cols;
        int          rows;
        int          col;
        int          row;
        int          nc;
        int          nr;
        int          count;
        int          pick;
        int          cand_col [SIDES];
        int          cand_row [SIDES];
        logic [1:0]  cand_side [SIDES];
        logic [1:0]  scan_order [SIDES] = '{SIDE_NORTH, SIDE_EAST, SIDE_SOUTH, SIDE_WEST};

        cols     = effective_dim(grid_cols_raw);
        rows     = effective_dim(grid_rows_raw);
        ev.kind  = EV_IGNORED;
        ev.col   = '0;
        ev.row   = '0;
        ev.side  = '0;
        ev.fin   = 1'b0;

        if (req == REQ_START) begin
            row           = int'(rnd) % rows;
            visited_cells = '0;
            trail_depth   = 0;
            carving       = 1'b1;
            mark_and_push(0, row);
            ev.kind = EV_ENTRANCE;
            ev.row  = OUT_CW'(row);
            ev.side = SIDE_WEST;
            return ev;
        end

        if (!carving || trail_depth == 0) begin
            carving = 1'b0;
            return ev;
        end

        col   = int'(trail_col[trail_depth - 1]);
        row   = int'(trail_row[trail_depth - 1]);
        count = 0;
        // neighbors are scanned north, east, south, west
        for (int s = 0; s < SIDES; s++) begin
            nc = col;
            nr = row;
            case (scan_order[s])
                SIDE_NORTH: nr = row - 1;
                SIDE_EAST:  nc = col + 1;
                SIDE_SOUTH: nr = row + 1;
                default:    nc = col - 1;
            endcase
            if (nc >= 0 && nc < cols && nr >= 0 && nr < rows
                    && !visited_cells[nr * GRID_MAX + nc]) begin
                cand_col[count]  = nc;
                cand_row[count]  = nr;
                cand_side[count] = scan_order[s];
                count++;
            end
        end

        if (count > 0) begin
            pick    = int'(rnd) % count;
            ev.kind = EV_CARVE;
            ev.col  = OUT_CW'(col);
            ev.row  = OUT_CW'(row);
            ev.side = cand_side[pick];
            mark_and_push(cand_col[pick], cand_row[pick]);
        end else if (trail_depth > 1) begin
            trail_depth--;
            ev.kind = EV_BACKTRACK;   // no wall removed, side stays zero
            ev.col  = OUT_CW'(col);
            ev.row  = OUT_CW'(row);
        end else begin
            // bottom cell exhausted: open the east exit and stop
            trail_depth = 0;
            carving     = 1'b0;
            ev.kind     = EV_EXIT;
            ev.col      = OUT_CW'(cols - 1);
            ev.row      = OUT_CW'(int'(rnd) % rows);
            ev.side     = SIDE_EAST;
            ev.fin      = 1'b1;
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and field-by-field check
    // ------------------------------------------------------------------
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int          mode_left   = 0;
    int          stall_left  = 0;

    // The receiver switches to a randomly chosen ready pattern whenever its mode runs out,
    // so that stalls land on every phase of the block's work.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(100, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RDY_LONG_STALLS: begin
                if (stall_left != 0) begin
                    m_ready    <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left <= $urandom_range(5, 30);
                    end
                end
            end
            default:    m_ready <= ~m_ready;
        endcase
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        maze_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("result beat with nothing expected: event_kind %0d", m_event_kind);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.kind, m_event_kind);
                check_field("cell_col", want.col, m_cell_col);
                check_field("cell_row", want.row, m_cell_row);
                check_field("wall_side", want.side, m_wall_side);
                check_field("finished", want.fin, m_finished);
            end
        end
    end

    // Watchdog: a run with no beat on either channel for too long is hung.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    int burst_left = 0;

    function automatic logic [RND_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return RND_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // Called at a clock edge. Valid stays high across back-to-back beats;
    // it drops only for a gap between bursts or a drain.
    task automatic send_request(logic req, logic [RND_W-1:0] rnd);
        int          gap;
        maze_event_t want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_random_value <= rnd;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = predict_carve(req, rnd);
        pending_events.push_back(want);
        if (want.kind != EV_IGNORED) begin
            work_items++;
        end
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic wait_for_events();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // Both dimension registers, one write per edge; block must be idle.
    task automatic set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GRID_COLUMNS;
        cfg_wdata <= cols;
        @(posedge aclk);
        grid_cols_raw = cols;
        cfg_index <= REG_GRID_ROWS;
        cfg_wdata <= rows;
        @(posedge aclk);
        grid_rows_raw = rows;
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Steps with no maze in progress are ignored and change nothing.
    task automatic test_steps_before_start();
        send_request(REQ_STEP, '0);
        send_request(REQ_STEP, '1);
    endtask

    // Zero dimensions act as a 1x1 grid: entrance, then exit at once,
    // then the block is back to ignoring steps.
    task automatic test_single_cell_grid();
        wait_for_events();
        set_grid('0, '0);
        send_request(REQ_START, '1);
        send_request(REQ_STEP, '1);
        send_request(REQ_STEP, '0);
    endtask

    // Oversized column register saturates; entrance lands on the last row.
    task automatic test_full_size_entrance();
        wait_for_events();
        set_grid('1, CFG_W'(GRID_MAX));
        send_request(REQ_START, '1);
        repeat (4) send_request(REQ_STEP, random_word());
    endtask

    // A start in the middle of a maze abandons it.
    task automatic test_restart_while_running();
        send_request(REQ_START, RND_W'(5));
        repeat (2) send_request(REQ_STEP, random_word());
    endtask

    // Shrink the grid under a running maze: stacked cells keep their
    // coordinates, the scan uses the new bounds.
    task automatic test_shrink_while_running();
        wait_for_events();
        set_grid(CFG_W'(2), CFG_W'(2));
        repeat (6) send_request(REQ_STEP, random_word());
    endtask

    // A 3x1 corridor carved to completion.
    task automatic test_narrow_grid_complete();
        wait_for_events();
        set_grid(CFG_W'(3), CFG_W'(1));
        send_request(REQ_START, RND_W'(1));
        while (carving) send_request(REQ_STEP, random_word());
    endtask

    // Whole mazes on random grids, mostly small, with the occasional long
    // corridor at full width or height, full-size grids cut short, and
    // rare restarts and resizes in the middle of a maze.
    task automatic test_random_mazes();
        int               target;
        int               steps;
        int               step_cap;
        int               roll;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        target = work_items + RANDOM_ITEMS;
        while (work_items < target) begin
            wait_for_events();
            step_cap = 1 << 20;
            case ($urandom_range(0, 19))
                0: begin
                    cols = $urandom_range(0, 1) ? '1 : CFG_W'(GRID_MAX);
                    rows = CFG_W'($urandom_range(0, 1));
                end
                1: begin
                    cols = CFG_W'($urandom_range(0, 1));
                    rows = $urandom_range(0, 1) ? '1 : CFG_W'(GRID_MAX);
                end
                2: begin
                    // full-size start; the maze itself is cut short
                    cols     = CFG_W'($urandom_range(GRID_MAX, 127));
                    rows     = CFG_W'($urandom_range(GRID_MAX, 127));
                    step_cap = 30;
                end
                3: begin
                    cols = '0;
                    rows = CFG_W'($urandom_range(0, 3));
                end
                default: begin
                    cols = CFG_W'($urandom_range(1, 12));
                    rows = CFG_W'($urandom_range(1, 12));
                end
            endcase
            set_grid(cols, rows);
            send_request(REQ_START, random_word());
            steps = 0;
            while (carving && steps < step_cap) begin
                roll = $urandom_range(0, 149);
                if (roll == 0) begin
                    send_request(REQ_START, random_word());
                end else if (roll == 1) begin
                    wait_for_events();
                    set_grid(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 10)));
                end else begin
                    send_request(REQ_STEP, random_word());
                end
                steps++;
            end
            // now and then poke the block after the maze is done or cut short
            if ($urandom_range(0, 3) == 0) begin
                send_request(REQ_STEP, random_word());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_steps_before_start();
        test_single_cell_grid();
        test_full_size_entrance();
        test_restart_while_running();
        test_shrink_while_running();
        test_narrow_grid_complete();
        test_random_mazes();

        wait_for_events();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
